@@ src/smpq_pkg.sv @@
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int DEF_DEPTH = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RM_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INS_FULL = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                       ins;
        logic                       rem;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctl;

endpackage

@@ src/smpq_cell.sv @@
`timescale 1ns / 1ps

module smpq_cell (
    input  logic                               i_clk,
    input  smpq_pkg::t_cell_ctl                i_ctl,
    input  logic                               i_occupied,
    input  logic                               i_prev_go,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_prev_value,
    input  logic signed [smpq_pkg::VALUE_W-1:0] i_next_value,
    output logic                               o_go,
    output logic signed [smpq_pkg::VALUE_W-1:0] o_value,
    output logic signed [smpq_pkg::VALUE_W-1:0] o_next_value
);
    import smpq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // An empty cell or a smaller entry gives way to the new value; equal entries stay ahead.
    assign o_go = !i_occupied || (r_value < i_ctl.value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (i_prev_go) begin
                n_value = i_prev_value;
            end else if (o_go) begin
                n_value = i_ctl.value;
            end
        end else if (i_ctl.rem) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;

endmodule

@@ src/sorted_max_priority_queue.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// command   in         i_valid / o_stall  i_cmd, i_value
// result    out        o_valid / i_stall  o_top_value, o_entry_count, o_is_empty, o_status
//
// One transaction per cycle while o_stall is low: every cell of the chain compares the
// value and shifts in the same cycle, and the result register is loaded at the edge
// that accepts.
// Reset clears the entry count and the result valid; cell contents are not reset.
// A command is stalled only while a result waits and the result side stalls.

module sorted_max_priority_queue #(
    parameter int DEPTH = smpq_pkg::DEF_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_cmd,
    input  logic signed [smpq_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [smpq_pkg::VALUE_W-1:0]  o_top_value,
    output logic        [smpq_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                                 o_is_empty,
    output logic        [smpq_pkg::STATUS_W-1:0] o_status
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_out_valid;
    logic signed [VALUE_W-1:0] r_top_value;
    logic [COUNT_W-1:0]  r_entry_count;
    logic                r_is_empty;
    logic [STATUS_W-1:0] r_status;

    logic                accept;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    t_cell_ctl           ctl;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    logic [DEPTH-1:0]                 occ;
    logic [DEPTH-1:0]                 go;
    logic signed [VALUE_W-1:0]        val      [DEPTH];
    logic signed [VALUE_W-1:0]        next_val [DEPTH];

    assign accept = i_valid && !o_stall;
    assign o_stall = r_out_valid && i_stall;
    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        ctl.value = i_value;
        ctl.ins   = 1'b0;
        ctl.rem   = 1'b0;
        status    = ST_OK;
        n_count   = r_count;
        if (accept) begin
            if (i_cmd == CMD_INSERT) begin
                if (full) begin
                    status = ST_INS_FULL;
                end else begin
                    ctl.ins = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    status = ST_RM_EMPTY;
                end else begin
                    ctl.rem = 1'b1;
                    n_count = r_count - CNT_W'(1);
                end
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                      prev_go;
            logic signed [VALUE_W-1:0] prev_value;
            logic signed [VALUE_W-1:0] below_value;

            assign occ[gi] = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_head
                assign prev_go    = 1'b0;
                assign prev_value = '0;
            end else begin : g_body
                assign prev_go    = go[gi-1];
                assign prev_value = val[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign below_value = '0;
            end else begin : g_mid
                assign below_value = val[gi+1];
            end

            smpq_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (ctl),
                .i_occupied   (occ[gi]),
                .i_prev_go    (prev_go),
                .i_prev_value (prev_value),
                .i_next_value (below_value),
                .o_go         (go[gi]),
                .o_value      (val[gi]),
                .o_next_value (next_val[gi])
            );
        end
    endgenerate

    assign count_ext = (CNT_W + COUNT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top_value   <= (n_count != '0) ? next_val[0] : '0;
            r_entry_count <= count_ext[COUNT_W-1:0];
            r_is_empty    <= (n_count == '0);
            r_status      <= status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_top_value;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_top_value == '0))
        else $error("empty result with nonzero top value");

    a_rm_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_REMOVE && empty) |=>
            (o_valid && o_status == ST_RM_EMPTY && o_is_empty))
        else $error("remove on empty not reported");

    a_ins_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_INSERT && full) |=>
            (o_status == ST_INS_FULL && $stable(r_count)))
        else $error("insert on full changed the queue");
`endif

endmodule

@@ bench/sorted_max_priority_queue_tb.sv @@
`timescale 1ns / 1ps

module sorted_max_priority_queue_tb;
    import smpq_pkg::*;

    localparam int DEPTH         = DEF_DEPTH;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 150;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int MAX_ERR_LINES = 20;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  top_value;
        logic        [COUNT_W-1:0]  entry_count;
        logic                       is_empty;
        logic        [STATUS_W-1:0] status;
    } t_front_report;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_cmd = CMD_INSERT;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [VALUE_W-1:0]  o_top_value;
    logic        [COUNT_W-1:0]  o_entry_count;
    logic                       o_is_empty;
    logic        [STATUS_W-1:0] o_status;

    // Shadow copy of the queue contents, updated as each command is accepted.
    logic signed [VALUE_W-1:0]  shadow_entries [DEPTH];
    int unsigned                shadow_count = 0;
    t_front_report              front_reports_due [$];

    int  error_count       = 0;
    int  commands_sent     = 0;
    int  results_checked   = 0;
    int  full_rejects      = 0;
    int  empty_removes     = 0;
    int  input_stall_count = 0;
    int  idle_cycles       = 0;
    bit  sender_quiet      = 1'b0;
    bit  receiver_quiet    = 1'b0;
    bit  hold_request      = 1'b0;

    sorted_max_priority_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_top_value   (o_top_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_front_report apply_command(input logic cmd,
                                                    input logic signed [VALUE_W-1:0] value);
        t_front_report rep;
        int unsigned   pos;
        rep.status = ST_OK;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                rep.status = ST_INS_FULL;
            end else begin
                // Equal values go behind the ones already stored.
                pos = 0;
                while (pos < shadow_count && shadow_entries[pos] >= value) pos++;
                for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
                shadow_entries[pos] = value;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                rep.status = ST_RM_EMPTY;
            end else begin
                for (int i = 0; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
                shadow_count--;
            end
        end
        rep.top_value   = (shadow_count > 0) ? shadow_entries[0] : '0;
        rep.entry_count = COUNT_W'(shadow_count);
        rep.is_empty    = (shadow_count == 0);
        return rep;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            5, 6:    v = $signed($urandom_range(0, 8)) - 4;
            7:       v = 32'sh7FFF_FFFF;
            8:       v = 32'sh8000_0000;
            9:       v = (shadow_count > 0) ?
                         shadow_entries[$urandom_range(0, shadow_count - 1)] : $urandom;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (error_count < MAX_ERR_LINES)
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $realtime, results_checked, field, got, want);
        error_count++;
    endtask

    // Called at a rising edge; returns at the edge that accepts the transaction.
    task automatic send_command(input logic cmd, input logic signed [VALUE_W-1:0] value);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        front_reports_due.push_back(apply_command(cmd, value));
        commands_sent++;
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        wait (front_reports_due.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic test_empty_and_extremes();
        send_command(CMD_REMOVE, 32'sd0);
        send_command(CMD_INSERT, 32'sh8000_0000);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sd0);
        send_command(CMD_INSERT, -32'sd1);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_REMOVE, 32'sh5A5A_5A5A);
    endtask

    task automatic test_fill_past_full();
        for (int i = 1; i <= 12; i++)
            send_command(CMD_INSERT, (i % 2) ? -(i * 1000) : i * 1000);
        send_command(CMD_INSERT, 32'sh7FFF_FFFF);
        send_command(CMD_INSERT, 32'sh8000_0000);
        wait_all_results();
    endtask

    // The receiver holds off while the sender keeps offering back to back.
    task automatic test_backpressure();
        hold_request = 1'b1;
        sender_quiet = 1'b1;
        for (int i = 0; i < 40; i++)
            send_command(($urandom_range(0, 1) == 0) ? CMD_INSERT : CMD_REMOVE, pick_value());
        sender_quiet = 1'b0;
        wait_all_results();
    endtask

    task automatic test_random_traffic();
        int insert_pct;
        int mode;
        for (int blk = 0; blk < RANDOM_ITEMS / 40; blk++) begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 20;
            endcase
            mode           = $urandom_range(0, 3);
            sender_quiet   = mode[0];
            receiver_quiet = mode[1];
            for (int i = 0; i < 40; i++)
                send_command(($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE,
                             pick_value());
        end
        sender_quiet   = 1'b0;
        receiver_quiet = 1'b0;
        wait_all_results();
    endtask

    // Result side: a random stall ahead of each transaction, plus one long hold on request.
    initial begin
        int stall_len;
        forever begin
            stall_len = receiver_quiet ? 0 : $urandom_range(0, 13);
            if (hold_request) begin
                stall_len    = stall_len + HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_front_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (front_reports_due.size() == 0) begin
                if (error_count < MAX_ERR_LINES)
                    $display("[%0t] result with no command outstanding", $realtime);
                error_count++;
            end else begin
                want = front_reports_due.pop_front();
                if (o_top_value !== want.top_value)
                    report_mismatch("top_value", o_top_value, want.top_value);
                if (o_entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_entry_count, want.entry_count);
                if (o_is_empty !== want.is_empty)
                    report_mismatch("is_empty", o_is_empty, want.is_empty);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (want.status == ST_INS_FULL) full_rejects++;
                if (want.status == ST_RM_EMPTY) empty_removes++;
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (i_valid && o_stall) input_stall_count++;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $realtime, IDLE_LIMIT);
                $display("** sorted_max_priority_queue: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_and_extremes();
        test_fill_past_full();
        test_backpressure();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (front_reports_due.size() != 0) begin
            $display("%0d expected results never arrived", front_reports_due.size());
            error_count++;
        end
        $display("Sent %0d commands and checked %0d results, %0d mismatches.",
                 commands_sent, results_checked, error_count);
        $display("Inserts on full: %0d, removes on empty: %0d, input stall cycles: %0d.",
                 full_rejects, empty_removes, input_stall_count);
        if (error_count == 0) begin
            $display("** sorted_max_priority_queue: PASSED **");
        end else begin
            $display("** sorted_max_priority_queue: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/smpq_pkg.sv
src/smpq_cell.sv
src/sorted_max_priority_queue.sv
bench/sorted_max_priority_queue_tb.sv
